@@ src/xtea_pkg.sv @@
`timescale 1ns / 1ps

package xtea_pkg;

    // golden ratio constant of the key schedule
    localparam logic [31:0] DELTA = 32'h9E37_79B9;

    localparam int WORD_W = 32;
    localparam int KEY_WORDS = 4;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_KEY_W0 = 2'd0,
        CFG_KEY_W1 = 2'd1,
        CFG_KEY_W2 = 2'd2,
        CFG_KEY_W3 = 2'd3
    } t_cfg_idx;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] t_key;

    // one block in flight: operation bit travels with the two words
    typedef struct packed {
        logic              op_dec;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
    } t_block;

    // feistel mixing term
    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] w);
        return ((w << 4) ^ (w >> 5)) + w;
    endfunction

endpackage

@@ src/xtea_round.sv @@
`timescale 1ns / 1ps

// one half-round of the cipher with a register behind it
module xtea_round #(
    parameter int STEP        = 0,
    parameter int ROUND_COUNT = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  xtea_pkg::t_block i_data,
    input  xtea_pkg::t_key  i_key,
    output logic            o_valid,
    output xtea_pkg::t_block o_data
);

    // running sum for this half-round, fixed per direction
    localparam int N_ENC = (STEP + 1) / 2;
    localparam int N_DEC = ROUND_COUNT - N_ENC;
    localparam logic [31:0] ENC_SUM = xtea_pkg::DELTA * 32'(N_ENC);
    localparam logic [31:0] DEC_SUM = xtea_pkg::DELTA * 32'(N_DEC);
    localparam logic ODD = 1'(STEP % 2);

    // key index: low bits when word a is updated, bits 12:11 when word b is
    localparam logic [1:0] ENC_SEL = ODD ? ENC_SUM[12:11] : ENC_SUM[1:0];
    localparam logic [1:0] DEC_SEL = ODD ? DEC_SUM[1:0] : DEC_SUM[12:11];

    logic             upd_b;
    logic [31:0]      sum;
    logic [31:0]      key_word;
    logic [31:0]      mixed;
    logic [31:0]      term;
    logic [31:0]      old_word;
    logic [31:0]      new_word;
    logic             r_valid;
    xtea_pkg::t_block r_data;

    // select the word to update and the round key term
    always_comb begin
        upd_b    = i_data.op_dec ^ ODD;
        sum      = i_data.op_dec ? DEC_SUM : ENC_SUM;
        key_word = i_data.op_dec ? i_key[DEC_SEL] : i_key[ENC_SEL];
        mixed    = xtea_pkg::mix(upd_b ? i_data.word_a : i_data.word_b);
        term     = mixed ^ (sum + key_word);
        old_word = upd_b ? i_data.word_b : i_data.word_a;
        new_word = i_data.op_dec ? (old_word - term) : (old_word + term);
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data.op_dec <= i_data.op_dec;
            r_data.word_a <= upd_b ? i_data.word_a : new_word;
            r_data.word_b <= upd_b ? new_word : i_data.word_b;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ src/xtea_out_buf.sv @@
`timescale 1ns / 1ps

// output register with a skid stage; pipeline moves while the skid is empty
module xtea_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  xtea_pkg::t_block i_data,
    output logic             o_pipe_en,
    output logic             o_valid,
    output logic [63:0]      o_data,
    input  logic             i_ready
);

    logic             r_out_valid;
    logic             r_skid_valid;
    xtea_pkg::t_block r_out;
    xtea_pkg::t_block r_skid;
    logic             take;
    logic             push;

    assign o_pipe_en = !r_skid_valid;
    assign take      = r_out_valid && i_ready;
    assign push      = !r_skid_valid && i_valid;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (r_out_valid && !take) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = {r_out.word_b, r_out.word_a};

endmodule

@@ src/xtea_block_cipher.sv @@
`timescale 1ns / 1ps

// XTEA block cipher, 64-bit block, 128-bit key, ROUND_COUNT rounds.
// key: four 32-bit words written through i_cfg_we / i_cfg_index / i_cfg_wdata,
//   index 0 to 3 picks the word; write only while no block is in flight.
// input stream: tdata holds first_word (low) and second_word (high),
//   tuser holds the operation bit (0 encrypt, 1 decrypt).
// output stream: tdata holds first_result (low) and second_result (high).
// each half-round is one pipeline stage, 2*ROUND_COUNT stages in all,
//   followed by an output register.
// throughput is one block per cycle while the pipeline is not held;
//   encrypt and decrypt blocks mix freely.
// a skid stage behind the output register lets one more block complete
//   while a result waits; after that the whole pipeline holds and input
//   tready drops until the receiver takes a transfer. nothing is lost.
// reset clears the key to zero and empties the pipeline.
module xtea_block_cipher #(
    parameter int ROUND_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // first_word[31:0], second_word[63:32]
    input  logic        i_s_axis_tuser,  // operation[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata   // first_result[31:0], second_result[63:32]
);

    localparam int STAGES = 2 * ROUND_COUNT;

    xtea_pkg::t_key   r_key;
    logic             pipe_en;
    logic             stage_valid [0:STAGES];
    xtea_pkg::t_block stage_data  [0:STAGES];

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            case (xtea_pkg::t_cfg_idx'(i_cfg_index))
                xtea_pkg::CFG_KEY_W0: r_key[0] <= i_cfg_wdata;
                xtea_pkg::CFG_KEY_W1: r_key[1] <= i_cfg_wdata;
                xtea_pkg::CFG_KEY_W2: r_key[2] <= i_cfg_wdata;
                xtea_pkg::CFG_KEY_W3: r_key[3] <= i_cfg_wdata;
                default: r_key <= r_key;
            endcase
        end
    end

    // input into the first stage
    assign o_s_axis_tready          = pipe_en;
    assign stage_valid[0]           = i_s_axis_tvalid;
    assign stage_data[0].op_dec     = i_s_axis_tuser;
    assign stage_data[0].word_a     = i_s_axis_tdata[31:0];
    assign stage_data[0].word_b     = i_s_axis_tdata[63:32];

    // half-round stages
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        xtea_round #(
            .STEP        (g),
            .ROUND_COUNT (ROUND_COUNT)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (stage_valid[g]),
            .i_data  (stage_data[g]),
            .i_key   (r_key),
            .o_valid (stage_valid[g+1]),
            .o_data  (stage_data[g+1])
        );
    end

    // output register and skid
    xtea_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_valid[STAGES]),
        .i_data    (stage_data[STAGES]),
        .o_pipe_en (pipe_en),
        .o_valid   (o_m_axis_tvalid),
        .o_data    (o_m_axis_tdata),
        .i_ready   (i_m_axis_tready)
    );

endmodule

@@ src/xtea_checker.sv @@
`timescale 1ns / 1ps

// port-level checks of the cipher top level
module xtea_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output changed");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("output not empty after reset");

    // input backpressure only follows a stalled output
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input ready dropped without output stall");

    // backpressure persists while the output stays stalled
    a_ready_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready && o_m_axis_tvalid && !i_m_axis_tready |=> !o_s_axis_tready)
        else $error("input ready rose during output stall");

    // a full skid implies a waiting result
    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input held off with no result waiting");

endmodule

bind xtea_block_cipher xtea_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
